/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_HOLDS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: condition does not hold");

// trigger in one cycle implies the outcome in the next
`define ASSERT_IMPLIES(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: expected outcome missing");

`endif

/* rtl/deq_pkg.sv */
package deq_pkg;

    localparam int ENTRY_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        REQ_PUSH_HEAD = 2'd0,
        REQ_PUSH_TAIL = 2'd1,
        REQ_POP_HEAD  = 2'd2,
        REQ_POP_TAIL  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-cell command, driven by the control logic for each cell every cycle
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_SHR   = 2'd1,
        CELL_SHL   = 2'd2,
        CELL_LOAD  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_req_type          req_type;
        logic [ENTRY_W-1:0] entry_value;
    } t_in_req;

    typedef struct packed {
        logic [ENTRY_W-1:0] front_value;
        logic               front_valid;
        logic [COUNT_W-1:0] entry_count;
        t_status            status;
    } t_out_res;

endpackage

/* rtl/deq_cell.sv */
module deq_cell (
    input  logic                       i_clk,
    input  deq_pkg::t_cell_op          i_op,
    input  logic [deq_pkg::ENTRY_W-1:0] i_load_value,
    input  logic [deq_pkg::ENTRY_W-1:0] i_prev_value,
    input  logic [deq_pkg::ENTRY_W-1:0] i_next_value,
    output logic [deq_pkg::ENTRY_W-1:0] o_value,
    output logic [deq_pkg::ENTRY_W-1:0] o_n_value
);
    import deq_pkg::*;

    logic [ENTRY_W-1:0] r_value;
    logic [ENTRY_W-1:0] n_value;

    // pick the new contents from the neighbors, the request or itself
    always_comb begin
        case (i_op)
            CELL_SHR:  n_value = i_prev_value;
            CELL_SHL:  n_value = i_next_value;
            CELL_LOAD: n_value = i_load_value;
            default:   n_value = r_value;
        endcase
    end

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value   = r_value;
    assign o_n_value = n_value;

endmodule

/* rtl/deq_out.sv */
module deq_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  deq_pkg::t_out_res i_data,
    output logic              o_full,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output deq_pkg::t_out_res o_out_data
);
    import deq_pkg::*;

    `include "assert_macros.svh"

    logic     r_main_valid;
    logic     r_skid_valid;
    t_out_res r_main;
    t_out_res r_skid;
    logic     w_main_free;

    assign w_main_free = !r_main_valid || !i_out_stall;

    // valid flags of the output register and the skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_main_free) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // result payloads
    always_ff @(posedge i_clk) begin
        if (w_main_free) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_valid) begin
            r_skid <= i_data;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_main_valid;
    assign o_out_data  = r_main;

    `ASSERT_HOLDS(a_skid_behind_main, i_clk, i_rst_n, !r_skid_valid || r_main_valid)
    `ASSERT_IMPLIES(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_out_stall, !r_skid_valid)

endmodule

/* rtl/double_ended_queue_core.sv */
// double-ended queue held in a row of shifting cells, front entry in cell 0
// input channel: i_in_valid / o_in_stall carry one request (req_type,
//   entry_value); a request is taken at a clock edge with valid high and
//   stall low
// output channel: o_out_valid / i_out_stall carry one result per request
//   (front entry, non-empty flag, entry count, status)
// registering: the result is registered in the output register, or in the skid stage while the receiver stalls
// throughput: one request per cycle while o_in_stall is low; a head push shifts every
//   cell right, a head pop shifts them left, a tail push loads the cell at the count,
//   a tail pop only lowers the count, so each request is finished in a single cell update
// receiver stall: a result waits in the output register and one more in a
//   skid stage; o_in_stall rises only while the skid stage is occupied
// reset: count goes to zero, both result stages empty; cell contents are
//   undefined and never shown, since only cells below the count are read
// status: done, pop on an empty queue ignored, push into a full queue
//   rejected; rejected or ignored requests leave the contents unchanged
module double_ended_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  deq_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output deq_pkg::t_out_res o_out_data
);
    import deq_pkg::*;

    `include "assert_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_push;
    t_status            w_status;
    t_cell_op           w_op      [DEPTH];
    logic [ENTRY_W-1:0] w_value   [DEPTH];
    logic [ENTRY_W-1:0] w_n_value [DEPTH];
    t_out_res           w_res;
    logic               w_out_full;

    assign w_accept   = i_in_valid && !w_out_full;
    assign o_in_stall = w_out_full;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_push     = (i_in_data.req_type == REQ_PUSH_HEAD) ||
                        (i_in_data.req_type == REQ_PUSH_TAIL);

    // count update and status
    always_comb begin
        n_count  = r_count;
        w_status = ST_DONE;
        if (w_accept) begin
            if (w_push) begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end else begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
        end
    end

    // command for each cell
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_op[i] = CELL_HOLD;
            if (w_accept) begin
                case (i_in_data.req_type)
                    REQ_PUSH_HEAD: begin
                        if (!w_full) w_op[i] = (i == 0) ? CELL_LOAD : CELL_SHR;
                    end
                    REQ_PUSH_TAIL: begin
                        if (!w_full && r_count == CW'(i)) w_op[i] = CELL_LOAD;
                    end
                    REQ_POP_HEAD: begin
                        if (!w_empty && i < DEPTH - 1) w_op[i] = CELL_SHL;
                    end
                    default: w_op[i] = CELL_HOLD;
                endcase
            end
        end
    end

    // row of cells, each wired to its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ENTRY_W-1:0] w_prev;
        logic [ENTRY_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = i_in_data.entry_value;
        end else begin : g_mid
            assign w_prev = w_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_value[g];
        end else begin : g_inner
            assign w_next = w_value[g+1];
        end
        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op[g]),
            .i_load_value (i_in_data.entry_value),
            .i_prev_value (w_prev),
            .i_next_value (w_next),
            .o_value      (w_value[g]),
            .o_n_value    (w_n_value[g])
        );
    end

    // count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result of the request, from the state after it
    always_comb begin
        w_res.front_valid = (n_count != '0);
        w_res.front_value = (n_count != '0) ? w_n_value[0] : '0;
        w_res.entry_count = COUNT_W'(n_count);
        w_res.status      = w_status;
    end

    deq_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_data      (w_res),
        .o_full      (w_out_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `ASSERT_HOLDS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `ASSERT_IMPLIES(a_full_push_kept, i_clk, i_rst_n, w_accept && w_full && w_push, $stable(r_count))
    `ASSERT_IMPLIES(a_empty_pop_kept, i_clk, i_rst_n, w_accept && w_empty && !w_push, r_count == '0)
    `ASSERT_IMPLIES(a_result_follows, i_clk, i_rst_n, w_accept, o_out_valid)

endmodule
